@@ hw/rtl/sft_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sft_pkg
// shared types and constants of the strings file tokenizer
// ----------------------------------------------------------------------------
package sft_pkg;

    localparam int FIELD_LIMIT = 1023;
    localparam int FLEN_W      = $clog2(FIELD_LIMIT + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LINE_W      = 16;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        KIND_KEY  = 3'd0,
        KIND_TEXT = 3'd1,
        KIND_PAIR = 3'd2,
        KIND_OK   = 3'd3,
        KIND_ERR  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_SYNTAX     = 3'd0,
        ERR_KEY_ESC    = 3'd1,
        ERR_KEY_OPEN   = 3'd2,
        ERR_NO_EQ      = 3'd3,
        ERR_NO_TEXT    = 3'd4,
        ERR_TEXT_ESC   = 3'd5,
        ERR_TEXT_OPEN  = 3'd6,
        ERR_NO_SEMI    = 3'd7
    } err_t;

    // classified input byte
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       is_space;
        logic       is_newline;
        logic       is_quote;
        logic       is_bslash;
        logic       is_slash;
        logic       is_star;
        logic       is_eq;
        logic       is_semi;
        logic       is_oct;
        logic       is_oct_lo;
        logic       esc_ok;
        logic [7:0] esc_byte;
    } class_t;

endpackage

`default_nettype wire

@@ hw/rtl/sft_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sft_front
// accepts input bytes and classifies them for the parser
// ----------------------------------------------------------------------------
module sft_front
    import sft_pkg::*;
(
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte[7:0]
    input  wire logic       s_tlast,   // is_end
    input  wire logic       q_full,
    output logic            q_push,
    output class_t          q_entry
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_entry            = '0;
        q_entry.data       = s_tdata;
        q_entry.is_end     = s_tlast || (s_tdata == CH_NUL);
        q_entry.is_space   = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
                             (s_tdata == CH_LF) || (s_tdata == CH_VT) ||
                             (s_tdata == CH_FF) || (s_tdata == CH_CR);
        q_entry.is_newline = (s_tdata == CH_LF);
        q_entry.is_quote   = (s_tdata == CH_QUOTE);
        q_entry.is_bslash  = (s_tdata == CH_BSLASH);
        q_entry.is_slash   = (s_tdata == CH_SLASH);
        q_entry.is_star    = (s_tdata == CH_STAR);
        q_entry.is_eq      = (s_tdata == CH_EQ);
        q_entry.is_semi    = (s_tdata == CH_SEMI);
        q_entry.is_oct     = (s_tdata >= CH_ZERO) && (s_tdata <= CH_SEVEN);
        q_entry.is_oct_lo  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_THREE);
        // simple escapes
        unique case (s_tdata)
            CH_BSLASH, CH_APOS, CH_QUOTE:
            begin
                q_entry.esc_ok   = 1'b1;
                q_entry.esc_byte = s_tdata;
            end
            CH_N:
            begin
                q_entry.esc_ok   = 1'b1;
                q_entry.esc_byte = CH_LF;
            end
            CH_R:
            begin
                q_entry.esc_ok   = 1'b1;
                q_entry.esc_byte = CH_CR;
            end
            CH_T:
            begin
                q_entry.esc_ok   = 1'b1;
                q_entry.esc_byte = CH_TAB;
            end
            default:
            begin
                q_entry.esc_ok   = 1'b0;
                q_entry.esc_byte = s_tdata;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/sft_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sft_queue
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module sft_queue
    import sft_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire class_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        valid,
    output class_t      head
);

    class_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_pop |=> count_reg == QCNT_W'(QUEUE_DEPTH))
        else $error("queue lost an entry while full");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sft_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sft_back
// entry parser state machine with registered result output
// ----------------------------------------------------------------------------
module sft_back
    import sft_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    input  wire class_t       q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // out_byte[7:0], error_code[10:8], line_number[26:11]
    output logic [2:0]        m_tuser    // kind[2:0]
);

    typedef enum logic [15:0] {
        PH_BETWEEN   = 16'h0001,
        PH_SLASH     = 16'h0002,
        PH_COMMENT   = 16'h0004,
        PH_CSTAR     = 16'h0008,
        PH_KEY       = 16'h0010,
        PH_KEY_ESC   = 16'h0020,
        PH_KEY_OCT1  = 16'h0040,
        PH_KEY_OCT2  = 16'h0080,
        PH_AFTER_KEY = 16'h0100,
        PH_BEF_TEXT  = 16'h0200,
        PH_TEXT      = 16'h0400,
        PH_TEXT_ESC  = 16'h0800,
        PH_TEXT_OCT1 = 16'h1000,
        PH_TEXT_OCT2 = 16'h2000,
        PH_AFTER_TXT = 16'h4000,
        PH_ERR       = 16'h8000
    } phase_t;

    phase_t              state_reg;
    phase_t              state_next;
    err_t                code_reg;
    err_t                code_next;
    logic [4:0]          oct_reg;
    logic [4:0]          oct_next;
    logic [FLEN_W-1:0]   len_reg;
    logic [FLEN_W-1:0]   len_next;
    logic [LINE_W-1:0]   line_reg;
    logic [LINE_W-1:0]   line_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    kind_t               out_kind_reg;
    logic [7:0]          out_byte_reg;
    err_t                out_code_reg;
    logic [LINE_W-1:0]   out_line_reg;

    logic                emit;
    kind_t               emit_kind;
    logic [7:0]          emit_byte;
    err_t                emit_code;
    logic                want;
    logic [7:0]          want_byte;
    logic                in_text;
    logic                end_ok;
    err_t                end_code;
    err_t                bad_code;
    phase_t              body_phase;
    logic [LINE_W-1:0]   line_inc;

    assign q_pop      = q_valid && (!out_valid_reg || m_tready);
    assign in_text    = (state_reg == PH_TEXT) || (state_reg == PH_TEXT_ESC) ||
                        (state_reg == PH_TEXT_OCT1) || (state_reg == PH_TEXT_OCT2);
    assign bad_code   = in_text ? ERR_TEXT_ESC : ERR_KEY_ESC;
    assign body_phase = in_text ? PH_TEXT : PH_KEY;
    assign line_inc   = (q_head.is_newline && (line_reg != '1)) ? line_reg + 1'b1 : line_reg;

    // report at end of data
    always_comb
    begin
        end_ok   = 1'b0;
        end_code = ERR_SYNTAX;
        unique case (state_reg)
            PH_BETWEEN, PH_COMMENT, PH_CSTAR: end_ok = 1'b1;
            PH_SLASH:                         end_code = ERR_SYNTAX;
            PH_KEY, PH_KEY_ESC:               end_code = ERR_KEY_OPEN;
            PH_KEY_OCT1, PH_KEY_OCT2:         end_code = ERR_KEY_ESC;
            PH_AFTER_KEY:                     end_code = ERR_NO_EQ;
            PH_BEF_TEXT:                      end_code = ERR_NO_TEXT;
            PH_TEXT:                          end_code = ERR_TEXT_OPEN;
            PH_TEXT_ESC, PH_TEXT_OCT1,
            PH_TEXT_OCT2:                     end_code = ERR_TEXT_ESC;
            PH_AFTER_TXT:                     end_code = ERR_NO_SEMI;
            PH_ERR:                           end_code = code_reg;
            default:                          end_code = code_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        oct_next   = oct_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        emit       = 1'b0;
        emit_kind  = KIND_KEY;
        emit_byte  = '0;
        emit_code  = ERR_SYNTAX;
        want       = 1'b0;
        want_byte  = q_head.data;

        if (q_pop)
        begin
            if (q_head.is_end)
            begin
                emit       = 1'b1;
                emit_kind  = end_ok ? KIND_OK : KIND_ERR;
                emit_code  = end_ok ? ERR_SYNTAX : end_code;
                state_next = PH_BETWEEN;
                code_next  = ERR_SYNTAX;
                oct_next   = '0;
                len_next   = '0;
                line_next  = LINE_W'(1);
            end
            else
            begin
                unique case (state_reg)
                    PH_BETWEEN:
                    begin
                        if (q_head.is_space)
                        begin
                            line_next = line_inc;
                        end
                        else if (q_head.is_slash)
                        begin
                            state_next = PH_SLASH;
                        end
                        else if (q_head.is_quote)
                        begin
                            len_next   = '0;
                            state_next = PH_KEY;
                        end
                        else
                        begin
                            state_next = PH_ERR;
                            code_next  = ERR_SYNTAX;
                        end
                    end
                    PH_SLASH:
                    begin
                        if (q_head.is_star)
                        begin
                            state_next = PH_COMMENT;
                        end
                        else
                        begin
                            state_next = PH_ERR;
                            code_next  = ERR_SYNTAX;
                        end
                    end
                    PH_COMMENT:
                    begin
                        line_next = line_inc;
                        if (q_head.is_star)
                        begin
                            state_next = PH_CSTAR;
                        end
                    end
                    PH_CSTAR:
                    begin
                        line_next = line_inc;
                        if (q_head.is_slash)
                        begin
                            state_next = PH_BETWEEN;
                        end
                        else if (!q_head.is_star)
                        begin
                            state_next = PH_COMMENT;
                        end
                    end
                    PH_KEY, PH_TEXT:
                    begin
                        if (q_head.is_quote)
                        begin
                            state_next = in_text ? PH_AFTER_TXT : PH_AFTER_KEY;
                        end
                        else if (q_head.is_bslash)
                        begin
                            state_next = in_text ? PH_TEXT_ESC : PH_KEY_ESC;
                        end
                        else
                        begin
                            want = 1'b1;
                        end
                    end
                    PH_KEY_ESC, PH_TEXT_ESC:
                    begin
                        if (q_head.esc_ok)
                        begin
                            want       = 1'b1;
                            want_byte  = q_head.esc_byte;
                            state_next = body_phase;
                        end
                        else if (q_head.is_oct_lo)
                        begin
                            oct_next   = {3'b000, q_head.data[1:0]};
                            state_next = in_text ? PH_TEXT_OCT1 : PH_KEY_OCT1;
                        end
                        else
                        begin
                            state_next = PH_ERR;
                            code_next  = bad_code;
                        end
                    end
                    PH_KEY_OCT1, PH_TEXT_OCT1:
                    begin
                        if (q_head.is_oct)
                        begin
                            oct_next   = {oct_reg[1:0], q_head.data[2:0]};
                            state_next = in_text ? PH_TEXT_OCT2 : PH_KEY_OCT2;
                        end
                        else
                        begin
                            state_next = PH_ERR;
                            code_next  = bad_code;
                        end
                    end
                    PH_KEY_OCT2, PH_TEXT_OCT2:
                    begin
                        if (q_head.is_oct)
                        begin
                            want       = 1'b1;
                            want_byte  = {oct_reg, q_head.data[2:0]};
                            oct_next   = '0;
                            state_next = body_phase;
                        end
                        else
                        begin
                            state_next = PH_ERR;
                            code_next  = bad_code;
                        end
                    end
                    PH_AFTER_KEY:
                    begin
                        if (q_head.is_space)
                        begin
                            line_next = line_inc;
                        end
                        else if (q_head.is_eq)
                        begin
                            state_next = PH_BEF_TEXT;
                        end
                        else
                        begin
                            state_next = PH_ERR;
                            code_next  = ERR_NO_EQ;
                        end
                    end
                    PH_BEF_TEXT:
                    begin
                        if (q_head.is_space)
                        begin
                            line_next = line_inc;
                        end
                        else if (q_head.is_quote)
                        begin
                            len_next   = '0;
                            state_next = PH_TEXT;
                        end
                        else
                        begin
                            state_next = PH_ERR;
                            code_next  = ERR_NO_TEXT;
                        end
                    end
                    PH_AFTER_TXT:
                    begin
                        if (q_head.is_semi)
                        begin
                            state_next = PH_BETWEEN;
                            emit       = 1'b1;
                            emit_kind  = KIND_PAIR;
                        end
                        else
                        begin
                            state_next = PH_ERR;
                            code_next  = ERR_NO_SEMI;
                        end
                    end
                    PH_ERR:
                    begin
                        state_next = PH_ERR;
                    end
                    default:
                    begin
                        state_next = PH_ERR;
                    end
                endcase

                // field byte, dropped beyond the limit
                if (want && (len_reg < FLEN_W'(FIELD_LIMIT)))
                begin
                    len_next  = len_reg + 1'b1;
                    emit      = 1'b1;
                    emit_kind = in_text ? KIND_TEXT : KIND_KEY;
                    emit_byte = want_byte;
                end
            end
        end
    end

    assign out_valid_next = (q_pop && emit) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_BETWEEN;
            code_reg      <= ERR_SYNTAX;
            oct_reg       <= '0;
            len_reg       <= '0;
            line_reg      <= LINE_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            oct_reg       <= oct_next;
            len_reg       <= len_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
            out_code_reg <= emit_code;
            out_line_reg <= line_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b00000, out_line_reg, out_code_reg, out_byte_reg};

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("parser phase not one-hot");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= FLEN_W'(FIELD_LIMIT))
        else $error("field length beyond limit");

    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_head.is_end |=> state_reg == PH_BETWEEN && line_reg == LINE_W'(1)
            && m_tvalid)
        else $error("end of data did not report and restart");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/strings_file_tokenizer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// strings_file_tokenizer_core
// byte-serial tokenizer for key/text entries of a strings file
//
// input stream: one byte per transfer in s_tdata, s_tlast marks end of data
// (a zero byte also ends the data). output stream: one result per transfer,
// m_tuser holds the kind (key byte, text byte, pair complete, success,
// error), m_tdata holds byte, error code and line number.
// one byte is taken every cycle while the queue is not full; a byte that
// yields a result is written to the queue when accepted, and a parser step
// then moves the result into the output register. the four-entry byte
// queue and the single output register set the buffering: when the
// receiver stalls, the parser stops at the output register and the queue
// fills, after which s_tready drops.
// end of data always yields a report and returns the parser to its start.
// reset empties the queue, drops any pending result and sets the line
// count to one.
// ----------------------------------------------------------------------------
module strings_file_tokenizer_core
    import sft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,   // is_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_byte[7:0], error_code[10:8], line_number[26:11]
    output logic [2:0]       m_tuser    // kind[2:0]
);

    class_t push_entry;
    class_t head_entry;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;

    sft_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    sft_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_entry)
    );

    sft_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
